### design/opmd_pkg.sv
// opmd_pkg: shared types and constants for the object pass minimum-distance detector
// no dependencies; used by every module of the block
package opmd_pkg;

    // field widths
    localparam int DIST_W     = 12;
    localparam int SKIP_W     = 8;
    localparam int LOWEST_W   = 14;
    localparam int CFG_W      = 12;
    localparam int CFG_ADDR_W = 2;

    // default ring size
    localparam int RING_DEPTH_DEF = 8;

    // running minimum value while no object is tracked
    localparam logic [LOWEST_W-1:0] LOWEST_IDLE = 14'd9999;

    // register reset values
    localparam logic [DIST_W-1:0] DETECT_LIMIT_RST = 12'd800;
    localparam logic [SKIP_W-1:0] ENTRY_SKIP_RST   = 8'd3;
    localparam logic [SKIP_W-1:0] EXIT_SKIP_RST    = 8'd3;
    localparam logic [DIST_W-1:0] EXIT_MARGIN_RST  = 12'd10;

    // register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] REG_DETECT_LIMIT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ENTRY_SKIP   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EXIT_SKIP    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_EXIT_MARGIN  = 2'd3;

    // operations of the shared add/subtract unit
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_ACC   = 2'd2,
        OP_DIV   = 2'd3
    } arith_op_t;

    // control bundle from the sequencer to the arithmetic unit
    typedef struct packed {
        arith_op_t op;
    } arith_ctrl_t;

endpackage

### design/object_pass_min_distance_detector.sv
// Object pass minimum-distance detector, top level: sequencer, tracking state,
// config registers and output register. Depends on opmd_pkg, opmd_ring, opmd_arith.
// An ordinary sample goes from S_IDLE through S_EVAL to S_OUT; a pass with a nonempty ring
// adds an S_SUM pass over the ring and 12+clog2(RING_DEPTH+1) S_DIV division steps.
// Samples are taken one at a time, only in S_IDLE; a held result in S_OUT stalls the next.
// Reset (rst_n low, asynchronous) loads register defaults and clears tracking.
module object_pass_min_distance_detector #(
    parameter int RING_DEPTH = opmd_pkg::RING_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [opmd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [opmd_pkg::CFG_W-1:0]        cfg_wdata,
    // sample input
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [opmd_pkg::DIST_W-1:0]       distance,
    // result output
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              passed,
    output logic [opmd_pkg::DIST_W-1:0]       mean_distance
);
    import opmd_pkg::*;

    localparam int IDX_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W   = DIST_W + FILL_W;
    localparam int CNT_MAX = (SUM_W > RING_DEPTH) ? SUM_W : RING_DEPTH;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_SUM  = 6'b000100,
        S_DIV  = 6'b001000,
        S_OUT  = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // config registers
    logic [DIST_W-1:0] detect_limit_reg;
    logic [SKIP_W-1:0] entry_skip_reg;
    logic [SKIP_W-1:0] exit_skip_reg;
    logic [DIST_W-1:0] exit_margin_reg;

    // tracking state
    logic [SKIP_W-1:0]   entry_left_reg, entry_left_next;
    logic [SKIP_W-1:0]   exit_left_reg, exit_left_next;
    logic [LOWEST_W-1:0] lowest_reg, lowest_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;

    // per-item working registers
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [FILL_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rdv_reg, rdv_next;
    logic              pass_reg, pass_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic              passed_reg, passed_next;
    logic [DIST_W-1:0] mean_reg, mean_next;

    // ring and arithmetic hookup
    logic              ring_we;
    logic [DIST_W-1:0] ring_rdata;
    arith_ctrl_t       actrl;
    logic [SUM_W-1:0]  quotient;

    // sample classification
    logic is_present, is_new_min, is_far;
    logic out_load;

    assign is_present = dist_reg < detect_limit_reg;
    assign is_new_min = (LOWEST_W'(dist_reg)) < lowest_reg;
    assign is_far     = (LOWEST_W+1)'(dist_reg) >
                        ((LOWEST_W+1)'(lowest_reg) + (LOWEST_W+1)'(exit_margin_reg));

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_limit_reg <= DETECT_LIMIT_RST;
            entry_skip_reg   <= ENTRY_SKIP_RST;
            exit_skip_reg    <= EXIT_SKIP_RST;
            exit_margin_reg  <= EXIT_MARGIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_DETECT_LIMIT: detect_limit_reg <= cfg_wdata[DIST_W-1:0];
                REG_ENTRY_SKIP:   entry_skip_reg   <= cfg_wdata[SKIP_W-1:0];
                REG_EXIT_SKIP:    exit_skip_reg    <= cfg_wdata[SKIP_W-1:0];
                REG_EXIT_MARGIN:  exit_margin_reg  <= cfg_wdata[DIST_W-1:0];
                default:          detect_limit_reg <= detect_limit_reg;
            endcase
        end
    end

    // sequencer and tracking update
    always_comb
    begin
        state_next      = state_reg;
        entry_left_next = entry_left_reg;
        exit_left_next  = exit_left_reg;
        lowest_next     = lowest_reg;
        pos_next        = pos_reg;
        fill_next       = fill_reg;
        dist_next       = dist_reg;
        div_next        = div_reg;
        cnt_next        = cnt_reg;
        rdv_next        = rdv_reg;
        pass_next       = pass_reg;
        ring_we         = 1'b0;
        actrl.op        = OP_HOLD;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dist_next  = distance;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                actrl.op   = OP_CLEAR;
                pass_next  = 1'b0;
                state_next = S_OUT;
                if (!is_present)
                begin
                    entry_left_next = entry_skip_reg;
                end
                else if (entry_left_reg != '0)
                begin
                    entry_left_next = entry_left_reg - 1'b1;
                end
                else if (is_new_min)
                begin
                    lowest_next    = LOWEST_W'(dist_reg);
                    ring_we        = 1'b1;
                    pos_next       = (pos_reg == IDX_W'(RING_DEPTH - 1)) ? '0
                                                                         : pos_reg + 1'b1;
                    if (fill_reg != FILL_W'(RING_DEPTH))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    exit_left_next = exit_skip_reg;
                end
                else if (is_far)
                begin
                    if (exit_left_reg != '0)
                    begin
                        exit_left_next = exit_left_reg - 1'b1;
                    end
                    else
                    begin
                        // object passed: snapshot fill as divisor, drop the track
                        pass_next       = 1'b1;
                        div_next        = fill_reg;
                        cnt_next        = '0;
                        rdv_next        = 1'b0;
                        entry_left_next = entry_skip_reg;
                        exit_left_next  = exit_skip_reg;
                        lowest_next     = LOWEST_IDLE;
                        pos_next        = '0;
                        fill_next       = '0;
                        if (fill_reg != '0)
                        begin
                            state_next = S_SUM;
                        end
                    end
                end
                else
                begin
                    exit_left_next = exit_skip_reg;
                end
            end
            S_SUM:
            begin
                // read address leads the accumulate through the registered ring read
                actrl.op = rdv_reg ? OP_ACC : OP_HOLD;
                if (cnt_reg < CNT_W'(div_reg))
                begin
                    cnt_next = cnt_reg + 1'b1;
                    rdv_next = 1'b1;
                end
                else
                begin
                    rdv_next = 1'b0;
                    cnt_next = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                actrl.op = OP_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        passed_next    = passed_reg;
        mean_next      = mean_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            passed_next    = pass_reg;
            mean_next      = quotient[DIST_W-1:0];
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            entry_left_reg <= ENTRY_SKIP_RST;
            exit_left_reg  <= EXIT_SKIP_RST;
            lowest_reg     <= LOWEST_IDLE;
            pos_reg        <= '0;
            fill_reg       <= '0;
            cnt_reg        <= '0;
            rdv_reg        <= 1'b0;
            pass_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            entry_left_reg <= entry_left_next;
            exit_left_reg  <= exit_left_next;
            lowest_reg     <= lowest_next;
            pos_reg        <= pos_next;
            fill_reg       <= fill_next;
            cnt_reg        <= cnt_next;
            rdv_reg        <= rdv_next;
            pass_reg       <= pass_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dist_reg   <= dist_next;
        div_reg    <= div_next;
        passed_reg <= passed_next;
        mean_reg   <= mean_next;
    end

    // ring of minima
    opmd_ring #(
        .DEPTH (RING_DEPTH),
        .IDX_W (IDX_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (pos_reg),
        .wr_data (dist_reg),
        .rd_addr (cnt_reg[IDX_W-1:0]),
        .rd_data (ring_rdata)
    );

    // shared accumulate / divide unit
    opmd_arith #(
        .SUM_W  (SUM_W),
        .FILL_W (FILL_W)
    ) u_arith (
        .clk      (clk),
        .ctrl     (actrl),
        .addend   (ring_rdata),
        .divisor  (div_reg),
        .quotient (quotient)
    );

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign passed        = passed_reg;
    assign mean_distance = mean_reg;

endmodule

### design/opmd_ring.sv
// opmd_ring: ring of recent minima, one write and one registered read per cycle
// depends on opmd_pkg for the distance width
module opmd_ring #(
    parameter int DEPTH = opmd_pkg::RING_DEPTH_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [IDX_W-1:0]            wr_addr,
    input  logic [opmd_pkg::DIST_W-1:0] wr_data,
    input  logic [IDX_W-1:0]            rd_addr,
    output logic [opmd_pkg::DIST_W-1:0] rd_data
);
    import opmd_pkg::*;

    logic [DIST_W-1:0] mem [DEPTH];
    logic [DIST_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/opmd_arith.sv
// opmd_arith: one shared adder/subtractor that accumulates the ring and then
// runs a restoring division one quotient bit per cycle; depends on opmd_pkg
module opmd_arith #(
    parameter int SUM_W  = 16,
    parameter int FILL_W = 4
) (
    input  logic                        clk,
    input  opmd_pkg::arith_ctrl_t       ctrl,
    input  logic [opmd_pkg::DIST_W-1:0] addend,
    input  logic [FILL_W-1:0]           divisor,
    output logic [SUM_W-1:0]            quotient
);
    import opmd_pkg::*;

    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic [FILL_W-1:0] rem_reg, rem_next;

    logic [FILL_W:0]   trial;
    logic [SUM_W:0]    opa, opb;
    logic              cin;
    logic [SUM_W+1:0]  sum_w;
    logic              fits;

    // partial remainder with the next dividend bit shifted in
    assign trial = {rem_reg, acc_reg[SUM_W-1]};

    // operand selection for the shared adder
    always_comb
    begin
        opa = '0;
        opb = '0;
        cin = 1'b0;
        unique case (ctrl.op)
            OP_ACC:
            begin
                opa = {1'b0, acc_reg};
                opb = (SUM_W+1)'(addend);
            end
            OP_DIV:
            begin
                opa = (SUM_W+1)'(trial);
                opb = ~((SUM_W+1)'(divisor));
                cin = 1'b1;
            end
            OP_HOLD, OP_CLEAR:
            begin
                opa = '0;
                opb = '0;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    // the shared adder; carry out on subtract means trial >= divisor
    assign sum_w = {1'b0, opa} + {1'b0, opb} + (SUM_W+2)'(cin);
    assign fits  = sum_w[SUM_W+1];

    // next state of accumulator / quotient and remainder
    always_comb
    begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        unique case (ctrl.op)
            OP_CLEAR:
            begin
                acc_next = '0;
                rem_next = '0;
            end
            OP_ACC:
            begin
                acc_next = sum_w[SUM_W-1:0];
            end
            OP_DIV:
            begin
                acc_next = {acc_reg[SUM_W-2:0], fits};
                rem_next = fits ? sum_w[FILL_W-1:0] : trial[FILL_W-1:0];
            end
            OP_HOLD:
            begin
                acc_next = acc_reg;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign quotient = acc_reg;

endmodule

### design/opmd_checker.sv
// opmd_checker: port-level checks for the object pass minimum-distance detector
// depends on opmd_pkg; bound to the top level at the end of this file
module opmd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              passed,
    input logic [opmd_pkg::DIST_W-1:0]       mean_distance
);
    import opmd_pkg::*;

    // a pending result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    // a pending result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(passed) && $stable(mean_distance))
        else $error("result payload changed while stalled");

    // no mean reported without a pass
    a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !passed |-> mean_distance == '0)
        else $error("mean nonzero on a non-pass result");

    // one sample in flight: busy right after an input transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted back to back");

endmodule

bind object_pass_min_distance_detector opmd_checker u_opmd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .passed        (passed),
    .mean_distance (mean_distance)
);
